// ===== rtl/brgbdc_pkg.sv =====
// Shared types and constants for the pushbutton RGB duty controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package brgbdc_pkg;

  // button sample layout
  localparam int unsigned BTN_BITS   = 5;
  localparam int unsigned BTN_BLUE   = 0;
  localparam int unsigned BTN_CLEAR  = 1;
  localparam int unsigned BTN_RED    = 2;
  localparam int unsigned BTN_GREEN  = 3;
  localparam int unsigned BTN_ENABLE = 4;

  // field and word widths
  localparam int unsigned FIELD_BITS    = 10;
  localparam int unsigned CW_BITS       = 32;
  localparam int unsigned CW_ENABLE_BIT = 31;
  localparam int unsigned DIGIT_BITS    = 4;
  localparam int unsigned PCT_BITS      = 7;
  localparam int unsigned IN_DATA_BITS  = 8;
  localparam int unsigned OUT_DATA_BITS = 56;

  // default duty register width
  localparam int unsigned DUTY_BITS_DEF = 10;

  // percent scaling: pct = duty * PCT_SCALE / PCT_DIVISOR
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned PCT_DIVISOR = 1023;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 10;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP_SIZE = 1'b0,
    CFG_DUTY_MAX  = 1'b1
  } cfg_idx_t;

  localparam logic [CFG_DATA_BITS-1:0] STEP_SIZE_RST = 10'd63;
  localparam logic [CFG_DATA_BITS-1:0] DUTY_MAX_RST  = 10'd1023;

  // two decimal digits of one percentage
  typedef struct packed {
    logic [DIGIT_BITS-1:0] tens;
    logic [DIGIT_BITS-1:0] ones;
  } digits_t;

endpackage : brgbdc_pkg

`default_nettype wire

// ===== rtl/button_rgb_duty_controller_core.sv =====
// Top level of the pushbutton RGB duty controller: button edge handling,
// duty state, config registers and result register. Depends on brgbdc_pkg
// and brgbdc_pct_digits.
//
// Each request on the in_ stream is one 5-bit pushbutton sample. Rising edges
// against the previous sample step the blue, red and green duties (wrapping to
// zero above duty_max), clear all duties, or toggle the PWM enable, in bit
// order. Every request yields one result: the packed control word and the
// decimal digits of each duty percentage. The block takes one request per
// cycle while not stalled. The updated duty state is registered first, and
// the result built from it then moves into the result register once that
// is free. The state registers stall the input only while a result waits
// and the result register is full. Config writes go to cfg_ only while the
// block is idle; the user must keep to this, the block does not enforce it.
`default_nettype none

module button_rgb_duty_controller_core #(
  parameter int unsigned DUTY_BITS = brgbdc_pkg::DUTY_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // sample stream; bits from low: buttons[4:0], zero pad [7:5]
  input  wire logic                                  in_tvalid,
  output      logic                                  in_tready,
  input  wire logic [brgbdc_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // result stream; bits from low: control_word[31:0], red_tens[35:32],
  // red_ones[39:36], green_tens[43:40], green_ones[47:44],
  // blue_tens[51:48], blue_ones[55:52]
  output      logic                                  out_tvalid,
  input  wire logic                                  out_tready,
  output      logic [brgbdc_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // config write port
  input  wire logic                                  cfg_we,
  input  wire logic [brgbdc_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
  input  wire logic [brgbdc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import brgbdc_pkg::*;

  localparam int unsigned SUM_BITS = ((DUTY_BITS > FIELD_BITS) ? DUTY_BITS : FIELD_BITS) + 1;

  // config registers
  logic [CFG_DATA_BITS-1:0] step_size_r;
  logic [CFG_DATA_BITS-1:0] duty_max_r;

  // duty state
  logic [BTN_BITS-1:0]  prev_btn_r, prev_btn_nxt;
  logic [DUTY_BITS-1:0] red_r, red_nxt;
  logic [DUTY_BITS-1:0] green_r, green_nxt;
  logic [DUTY_BITS-1:0] blue_r, blue_nxt;
  logic                 pwm_on_r, pwm_on_nxt;

  // handshake state
  logic pend_r, pend_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 out_load;
  logic [BTN_BITS-1:0]  btn;
  logic [BTN_BITS-1:0]  rise;
  logic [DUTY_BITS-1:0] red_base, green_base;
  logic [SUM_BITS-1:0]  red_sum, green_sum, blue_sum;
  logic [DUTY_BITS-1:0] red_adv, green_adv, blue_adv;

  logic [FIELD_BITS-1:0] red_fld, green_fld, blue_fld;
  logic [CW_BITS-1:0]    ctrl_word;
  digits_t               red_dig, green_dig, blue_dig;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r <= STEP_SIZE_RST;
      duty_max_r  <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_STEP_SIZE: step_size_r <= cfg_wdata;
        CFG_DUTY_MAX:  duty_max_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_load  = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !pend_r || out_load;
  assign in_fire   = in_tvalid && in_tready;

  assign btn  = in_tdata[BTN_BITS-1:0];
  assign rise = btn & ~prev_btn_r;

  // step units; a clear earlier in bit order resets red and green first
  assign red_base   = rise[BTN_CLEAR] ? '0 : red_r;
  assign green_base = rise[BTN_CLEAR] ? '0 : green_r;

  assign blue_sum  = SUM_BITS'(blue_r) + SUM_BITS'(step_size_r);
  assign red_sum   = SUM_BITS'(red_base) + SUM_BITS'(step_size_r);
  assign green_sum = SUM_BITS'(green_base) + SUM_BITS'(step_size_r);

  assign blue_adv  = (blue_sum <= SUM_BITS'(duty_max_r)) ? DUTY_BITS'(blue_sum) : '0;
  assign red_adv   = (red_sum <= SUM_BITS'(duty_max_r)) ? DUTY_BITS'(red_sum) : '0;
  assign green_adv = (green_sum <= SUM_BITS'(duty_max_r)) ? DUTY_BITS'(green_sum) : '0;

  // next duty state for an accepted sample
  always_comb begin
    prev_btn_nxt = prev_btn_r;
    red_nxt      = red_r;
    green_nxt    = green_r;
    blue_nxt     = blue_r;
    pwm_on_nxt   = pwm_on_r;
    if (in_fire) begin
      prev_btn_nxt = btn;
      red_nxt      = rise[BTN_RED] ? red_adv : red_base;
      green_nxt    = rise[BTN_GREEN] ? green_adv : green_base;
      if (rise[BTN_CLEAR]) begin
        blue_nxt = '0;
      end else if (rise[BTN_BLUE]) begin
        blue_nxt = blue_adv;
      end
      if (rise[BTN_ENABLE]) begin
        pwm_on_nxt = !pwm_on_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r <= '0;
      red_r      <= '0;
      green_r    <= '0;
      blue_r     <= '0;
      pwm_on_r   <= 1'b1;
    end else begin
      prev_btn_r <= prev_btn_nxt;
      red_r      <= red_nxt;
      green_r    <= green_nxt;
      blue_r     <= blue_nxt;
      pwm_on_r   <= pwm_on_nxt;
    end
  end

  // result from the updated state
  assign red_fld   = FIELD_BITS'(red_r);
  assign green_fld = FIELD_BITS'(green_r);
  assign blue_fld  = FIELD_BITS'(blue_r);

  assign ctrl_word = {pwm_on_r, 1'b0, red_fld, green_fld, blue_fld};

  brgbdc_pct_digits u_red_pct   (.duty(red_fld),   .digits(red_dig));
  brgbdc_pct_digits u_green_pct (.duty(green_fld), .digits(green_dig));
  brgbdc_pct_digits u_blue_pct  (.duty(blue_fld),  .digits(blue_dig));

  assign out_data_nxt = {blue_dig.ones, blue_dig.tens, green_dig.ones, green_dig.tens,
                         red_dig.ones, red_dig.tens, ctrl_word};

  // pending flag and output valid
  assign pend_nxt      = in_fire || (pend_r && !out_load);
  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // a waiting result with a full output must hold off new samples
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("sample taken while state and result registers are both full");

  // every taken sample leaves a pending result
  a_fire_pends: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted sample did not raise pending");

  // enable bit of a loaded result follows the state it was built from
  a_enable_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tdata[CW_ENABLE_BIT] == $past(pwm_on_r))
    else $error("result enable bit does not match state");

  // a clear edge leaves blue at zero
  a_clear_blue: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && rise[BTN_CLEAR] |=> blue_r == '0)
    else $error("blue duty not cleared");
`endif

endmodule : button_rgb_duty_controller_core

`default_nettype wire

// ===== rtl/brgbdc_pct_digits.sv =====
// Converts one 10-bit duty field to the tens and ones digits of its percentage.
// Depends on brgbdc_pkg (widths, digits_t).
`default_nettype none

module brgbdc_pct_digits (
  input  wire logic [brgbdc_pkg::FIELD_BITS-1:0] duty,
  output brgbdc_pkg::digits_t                    digits
);
  import brgbdc_pkg::*;

  localparam int unsigned PROD_BITS = FIELD_BITS + PCT_BITS;

  logic [PROD_BITS-1:0]    prod;
  logic [PCT_BITS-1:0]     quo_est;
  logic [FIELD_BITS:0]     rem;
  logic [PCT_BITS-1:0]     pct;
  logic [DIGIT_BITS-1:0]   tens_raw;
  logic [PCT_BITS-1:0]     ones_wide;

  // duty * 100 as shifts and adds (64 + 32 + 4)
  assign prod = (PROD_BITS'(duty) << 6) + (PROD_BITS'(duty) << 5) + (PROD_BITS'(duty) << 2);

  // divide by 1023 = 1024 - 1: estimate by a shift, remainder stays below
  // twice the divisor, so one compare fixes the quotient
  assign quo_est = prod[PROD_BITS-1:FIELD_BITS];
  assign rem     = {1'b0, prod[FIELD_BITS-1:0]} + (FIELD_BITS+1)'(quo_est);
  assign pct     = (rem >= (FIELD_BITS+1)'(PCT_DIVISOR)) ? quo_est + 1'b1 : quo_est;

  // tens by independent threshold compares
  always_comb begin
    tens_raw = '0;
    for (int k = 1; k <= 10; k++) begin
      if (pct >= PCT_BITS'(k * 10)) begin
        tens_raw = DIGIT_BITS'(k);
      end
    end
  end

  assign ones_wide = pct - ((PCT_BITS'(tens_raw) << 3) + (PCT_BITS'(tens_raw) << 1));

  // full scale shows tens as zero
  assign digits.tens = (tens_raw == DIGIT_BITS'(10)) ? '0 : tens_raw;
  assign digits.ones = ones_wide[DIGIT_BITS-1:0];

endmodule : brgbdc_pct_digits

`default_nettype wire
